/* hw/rtl/ras_pkg.sv */
`default_nettype none
package ras_pkg;

  // Width of the configuration register (signed setting).
  localparam int SETTING_W = 7;
  // Reset value of the setting: store mode with depth 32.
  localparam logic [SETTING_W-1:0] SETTING_RESET = 7'd32;
  // The entry count is sized for the largest setting magnitude (64).
  localparam int COUNT_W = 7;
  localparam int DEPTH_OUT_W = 6;
  localparam int ADDR_PORT_W = 64;

  localparam int RING_DEPTH_DEF = 32;
  localparam int ADDR_BITS_DEF = 64;

  // Request codes.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } ras_shift_t;

endpackage
`default_nettype wire

/* hw/rtl/ras_cell.sv */
`default_nettype none
module ras_cell import ras_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire ras_shift_t           shift,
  input  wire logic [ADDR_BITS-1:0] from_newer,
  input  wire logic [ADDR_BITS-1:0] from_older,
  output logic      [ADDR_BITS-1:0] data_o
);

  logic [ADDR_BITS-1:0] data_r;
  logic [ADDR_BITS-1:0] data_nxt;

  // A push moves every entry one cell deeper, a pop one cell toward the top.
  always_comb begin
    priority if (shift.push) begin
      data_nxt = from_newer;
    end else if (shift.pop) begin
      data_nxt = from_older;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule
`default_nettype wire

/* hw/rtl/ras_ctrl.sv */
`default_nettype none
module ras_ctrl import ras_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [SETTING_W-1:0]   cfg_wdata,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   in_req_type,
  input  wire logic [ADDR_BITS-1:0]   top_data,
  output ras_shift_t                  shift,
  output logic                        out_valid,
  output logic [ADDR_PORT_W-1:0]      out_pop_addr,
  output logic                        out_was_empty,
  output logic [DEPTH_OUT_W-1:0]      out_depth_now
);

  localparam logic [8:0] RING_DEPTH_W = 9'(RING_DEPTH);

  logic [SETTING_W-1:0]   setting_r;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic                   busy_r;
  logic                   valid_r;
  logic [ADDR_PORT_W-1:0] pop_addr_r, pop_addr_nxt;
  logic                   empty_r, empty_nxt;

  logic                   store_mode;
  logic [COUNT_W-1:0]     magnitude;
  logic [COUNT_W-1:0]     depth;
  logic                   accept;
  logic                   is_pop;
  logic                   count_zero;

  // Negative settings select counter mode; their magnitude is 128 minus the code.
  assign store_mode = (setting_r != '0) && !setting_r[SETTING_W-1];
  assign magnitude  = setting_r[SETTING_W-1] ? COUNT_W'(8'd128 - {1'b0, setting_r})
                                             : setting_r;
  assign depth      = ({2'b00, magnitude} > RING_DEPTH_W) ? COUNT_W'(RING_DEPTH)
                                                          : magnitude;

  assign accept     = start && !busy_r;
  assign is_pop     = (in_req_type == REQ_POP);
  assign count_zero = (count_r == '0);

  always_comb begin
    count_nxt    = count_r;
    pop_addr_nxt = '0;
    empty_nxt    = 1'b0;
    shift.push   = 1'b0;
    shift.pop    = 1'b0;
    if (accept) begin
      if (!is_pop) begin
        shift.push = store_mode;
        if (count_r < depth) begin
          count_nxt = count_r + COUNT_W'(1);
        end
      end else if (count_zero) begin
        pop_addr_nxt = ADDR_PORT_W'(1);
        empty_nxt    = 1'b1;
      end else begin
        count_nxt = count_r - COUNT_W'(1);
        shift.pop = store_mode;
        if (store_mode) begin
          pop_addr_nxt[ADDR_BITS-1:0] = top_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setting_r <= SETTING_RESET;
      count_r   <= '0;
      busy_r    <= 1'b1;
      valid_r   <= 1'b0;
    end else begin
      busy_r  <= 1'b0;
      valid_r <= accept;
      if (cfg_we) begin
        setting_r <= cfg_wdata;
        count_r   <= '0;
      end else begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    pop_addr_r <= pop_addr_nxt;
    empty_r    <= empty_nxt;
  end

  assign busy          = busy_r;
  assign out_valid     = valid_r;
  assign out_pop_addr  = pop_addr_r;
  assign out_was_empty = empty_r;
  assign out_depth_now = count_r[DEPTH_OUT_W-1:0];

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> valid_r)
    else $error("accepted request produced no result");

  a_empty_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && empty_r) |-> (pop_addr_r == ADDR_PORT_W'(1) && count_r == '0))
    else $error("empty pop with wrong sentinel or nonzero count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= depth)
    else $error("entry count exceeds effective depth");

  a_no_shift_counter: assert property (@(posedge clk) disable iff (!rst_n)
    !store_mode |-> (!shift.push && !shift.pop))
    else $error("cell chain shifted in counter mode");
`endif

endmodule
`default_nettype wire

/* hw/rtl/return_address_ring_stack_top.sv */
`default_nettype none
// Return-address stack. Each request is a push (in_req_type 0) of in_ret_addr or a pop
// (in_req_type 1); a request is taken on a rising edge with start high and busy low, and
// exactly one result appears on the out_ ports, marked by out_valid for a single cycle. The
// receiver cannot stall, so results must be captured when out_valid is high. The block takes
// one request every cycle while busy is low; busy is high only during reset and in the cycle
// after it. In store mode the entries live in a chain of RING_DEPTH cells that all shift
// together: a push moves every entry one cell deeper and loads the new address at the top,
// a pop moves every entry one cell up, and the top cell is the popped value. When the stack
// is full a push drops the oldest entry off the end of the active depth and the count stays
// saturated. A positive setting on cfg_wdata selects store mode with that depth; zero or a
// negative setting keeps only a counter with depth equal to the magnitude; the depth never
// exceeds RING_DEPTH. A pop on an empty stack returns 1 with out_was_empty set, a pop in
// counter mode returns 0, and every push returns 0. out_depth_now is the entry count after
// the request. Writing the setting empties the stack; write it only when idle.
module return_address_ring_stack_top import ras_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [SETTING_W-1:0]   cfg_wdata,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   in_req_type,
  input  wire logic [ADDR_PORT_W-1:0] in_ret_addr,
  output logic                        out_valid,
  output logic [ADDR_PORT_W-1:0]      out_pop_addr,
  output logic                        out_was_empty,
  output logic [DEPTH_OUT_W-1:0]      out_depth_now
);

  ras_shift_t           shift;
  logic [ADDR_BITS-1:0] cell_data [RING_DEPTH];

  ras_ctrl #(
    .RING_DEPTH(RING_DEPTH),
    .ADDR_BITS (ADDR_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .top_data     (cell_data[0]),
    .shift        (shift),
    .out_valid    (out_valid),
    .out_pop_addr (out_pop_addr),
    .out_was_empty(out_was_empty),
    .out_depth_now(out_depth_now)
  );

  // Cell 0 is the top of the stack; a push feeds it the incoming address and the
  // deepest cell refills with zero on a pop.
  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    logic [ADDR_BITS-1:0] newer;
    logic [ADDR_BITS-1:0] older;

    if (i == 0) begin : g_first
      assign newer = in_ret_addr[ADDR_BITS-1:0];
    end else begin : g_inner
      assign newer = cell_data[i-1];
    end

    if (i == RING_DEPTH - 1) begin : g_last
      assign older = '0;
    end else begin : g_mid
      assign older = cell_data[i+1];
    end

    ras_cell #(
      .ADDR_BITS(ADDR_BITS)
    ) u_cell (
      .clk       (clk),
      .shift     (shift),
      .from_newer(newer),
      .from_older(older),
      .data_o    (cell_data[i])
    );
  end

endmodule
`default_nettype wire

/* tb/sv/tb_return_address_ring_stack_top.sv */
`timescale 1ns / 100ps
`default_nettype none

// Self-checking testbench for the return-address ring stack.
//
// A small tracker class keeps its own copy of the stack: the setting, the ring of
// addresses, the top slot and the entry count. Every request that the block accepts is
// fed to the tracker. The tracker works out the answer the block must give and queues it.
// Every result that the block strobes out is compared, field by field, with the oldest
// queued answer.
//
// Stimulus starts with a short directed part. It covers an empty pop, extreme addresses
// read back in order, a depth of one with overwrite, a zero setting and a negative
// (counter-only) setting that saturates. After that come random phases, one per setting.
// Each phase is mostly push bursts followed by pop bursts, so that the ring fills, wraps
// and drains, with single random requests mixed in.
module tb_return_address_ring_stack_top;
  import ras_pkg::*;

  // A phase with no accepted request and no result for this long means the block hung.
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 145;

  typedef struct {
    logic [ADDR_PORT_W-1:0] pop_addr;
    logic                   was_empty;
    logic [DEPTH_OUT_W-1:0] depth_now;
  } stack_answer_t;

  // Tracks the architectural state of the stack and the answers still owed by the block.
  class return_stack_tracker;
    logic [SETTING_W-1:0]   setting;
    logic [ADDR_PORT_W-1:0] ring [RING_DEPTH_DEF];
    int unsigned            top;
    int unsigned            count;
    stack_answer_t          answers [$];
    int                     mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      mismatches = 0;
      write_setting(SETTING_RESET);
    endfunction

    function void write_setting(logic [SETTING_W-1:0] value);
      setting = value;
      top     = 0;
      count   = 0;
      ring[0] = '0;
    endfunction

    function bit stores_addresses();
      return setting != '0 && !setting[SETTING_W-1];
    endfunction

    function int unsigned active_depth();
      int unsigned mag;
      mag = setting;
      if (setting[SETTING_W-1]) mag = (1 << SETTING_W) - mag;
      if (mag > RING_DEPTH_DEF) mag = RING_DEPTH_DEF;
      return mag;
    endfunction

    function int pending();
      return answers.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    function void note_request(logic kind, logic [ADDR_PORT_W-1:0] addr);
      stack_answer_t want;
      int unsigned   depth;
      int unsigned   prev;
      depth          = active_depth();
      want.pop_addr  = '0;
      want.was_empty = 1'b0;
      if (kind == REQ_PUSH) begin
        if (stores_addresses()) begin
          top = (top + 1 >= depth) ? 0 : top + 1;
          ring[top] = addr;
        end
        if (count < depth) count++;
      end else if (count == 0) begin
        want.pop_addr  = 1;
        want.was_empty = 1'b1;
      end else begin
        count--;
        if (stores_addresses()) begin
          prev = top;
          top  = (top == 0) ? depth - 1 : top - 1;
          want.pop_addr = ring[prev];
        end
      end
      want.depth_now = DEPTH_OUT_W'(count);
      answers.push_back(want);
    endfunction

    task check_result(logic [ADDR_PORT_W-1:0] addr, logic empty,
                      logic [DEPTH_OUT_W-1:0] depth);
      stack_answer_t want;
      if (answers.size() == 0) begin
        report("result strobed with no request outstanding");
        return;
      end
      want = answers.pop_front();
      if (addr !== want.pop_addr)
        report($sformatf("pop_addr %h, expected %h", addr, want.pop_addr));
      if (empty !== want.was_empty)
        report($sformatf("was_empty %b, expected %b", empty, want.was_empty));
      if (depth !== want.depth_now)
        report($sformatf("depth_now %0d, expected %0d", depth, want.depth_now));
    endtask
  endclass

  // Every block input starts at a known value; reset is held from time zero.
  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_we      = 1'b0;
  logic [SETTING_W-1:0]   cfg_wdata   = '0;
  logic                   start       = 1'b0;
  logic                   in_req_type = REQ_PUSH;
  logic [ADDR_PORT_W-1:0] in_ret_addr = '0;
  logic                   busy;
  logic                   out_valid;
  logic [ADDR_PORT_W-1:0] out_pop_addr;
  logic                   out_was_empty;
  logic [DEPTH_OUT_W-1:0] out_depth_now;

  return_stack_tracker tracker = new();
  bit                  sender_idles = 1'b1;
  int                  stall_cycles = 0;

  return_address_ring_stack_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_ret_addr  (in_ret_addr),
    .out_valid    (out_valid),
    .out_pop_addr (out_pop_addr),
    .out_was_empty(out_was_empty),
    .out_depth_now(out_depth_now)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Monitor. All inputs change through nonblocking assignments at the rising edge, so the
  // values read here are the ones the block saw at this edge. The result is checked before
  // the request is noted; a request's result is registered, so it never comes at the same
  // edge as the request. The same block runs the watchdog on cycles with no progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_result(out_pop_addr, out_was_empty, out_depth_now);
      if (cfg_we) tracker.write_setting(cfg_wdata);
      if (start && !busy) tracker.note_request(in_req_type, in_ret_addr);
    end
    if (out_valid || (rst_n && start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_return_address_ring_stack_top NOT OK");
      $finish;
    end
  end

  // Mostly random addresses, with the all-zero and all-one patterns now and then.
  function automatic logic [ADDR_PORT_W-1:0] pick_addr();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one request and hold it until the block takes it. A random idle gap may come
  // first, which lowers start. The request stays high when the next one follows
  // straight on.
  task automatic send_request(input logic kind, input logic [ADDR_PORT_W-1:0] addr);
    while (sender_idles && $urandom_range(99) < 17) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= kind;
    in_ret_addr <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and wait until every queued answer has been matched. Polling on the falling
  // edge keeps this clear of the monitor's work at the rising edge.
  task automatic drain_requests();
    start <= 1'b0;
    @(negedge clk);
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // The setting is only written with the block idle, since a write empties the stack.
  task automatic load_setting(input logic [SETTING_W-1:0] value);
    drain_requests();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random phase. Push bursts run up to a few past the depth, so that full-ring
  // overwrites happen. Pop bursts may run past the count, so that empty pops happen too.
  task automatic run_phase(input int budget);
    int          done;
    int unsigned depth;
    int unsigned pushes;
    int unsigned pops;
    done  = 0;
    depth = tracker.active_depth();
    while (done < budget) begin
      if ($urandom_range(9) < 7) begin
        pushes = $urandom_range(depth + 4, 0);
        pops   = $urandom_range(pushes + 2, 0);
        repeat (pushes) send_request(REQ_PUSH, pick_addr());
        repeat (pops) send_request(REQ_POP, pick_addr());
        done += pushes + pops;
      end else begin
        send_request(($urandom_range(1) == 0) ? REQ_PUSH : REQ_POP, pick_addr());
        done++;
      end
    end
  endtask

  initial begin
    logic [SETTING_W-1:0] settings [13];
    int                   waited;
    settings = '{7'd32, 7'd1, 7'd2, 7'd5, 7'd31, 7'd33, 7'd63, 7'd0,
                 7'h7F, 7'h40, 7'h60, 7'h79, 7'd0};
    settings[12] = SETTING_W'($urandom_range(127));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: a pop on the empty stack first, then extreme addresses read back in
    // last-in first-out order.
    send_request(REQ_POP, '1);
    send_request(REQ_PUSH, '0);
    send_request(REQ_PUSH, '1);
    send_request(REQ_PUSH, {32{2'b10}});
    send_request(REQ_PUSH, {32{2'b01}});
    repeat (4) send_request(REQ_POP, '0);

    // Depth one: the second push overwrites the first, so only one pop returns data.
    load_setting(7'd1);
    send_request(REQ_PUSH, 64'h0123_4567_89AB_CDEF);
    send_request(REQ_PUSH, 64'hFEDC_BA98_7654_3210);
    send_request(REQ_POP, '0);
    send_request(REQ_POP, '0);

    // A zero setting has no depth: the push changes nothing and the pop finds it empty.
    load_setting(7'd0);
    send_request(REQ_PUSH, '1);
    send_request(REQ_POP, '0);

    // A setting of minus three only counts. The count saturates at three, counted pops
    // return zero, and the fourth pop is empty.
    load_setting(7'h7D);
    repeat (4) send_request(REQ_PUSH, '1);
    repeat (4) send_request(REQ_POP, '0);

    // Random phases over the setting list, including the positive and negative extremes
    // and settings past the ring size. The phases for settings 31 and 33 run without sender gaps.
    foreach (settings[i]) begin
      load_setting(settings[i]);
      sender_idles = !(i == 4 || i == 5);
      run_phase(PHASE_ITEMS);
    end

    // Wait for the last answers, with a bound, then let the clock run on so that any stray
    // result shows.
    start <= 1'b0;
    waited = 0;
    while (tracker.pending() != 0 && waited < 200) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d answers never arrived", tracker.pending()));

    if (tracker.mismatches == 0) begin
      $display("tb_return_address_ring_stack_top OK");
    end else begin
      $display("tb_return_address_ring_stack_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
